// ----- src/window_majority_direction_vote_defines.svh -----
// assertion macros for the direction vote block and its checker
`ifndef WINDOW_MAJORITY_DIRECTION_VOTE_DEFINES_SVH
`define WINDOW_MAJORITY_DIRECTION_VOTE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WMDV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WMDV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/wmdv_pkg.sv -----
// shared types and constants for the direction vote block
package wmdv_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int NUM_DIR      = 3;
  localparam int PCT_SCALE    = 100;
  localparam int CMP_W        = $clog2(128 * WINDOW_DEPTH + 1);

  typedef logic [1:0]       label_t;
  typedef logic [7:0]       conf_t;
  typedef logic [6:0]       pct_t;
  typedef logic [4:0]       vote_t;
  typedef logic [7:0]       cfg_data_t;
  typedef logic [0:0]       cfg_idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [PTR_W-1:0] ptr_t;

  localparam label_t LBL_LEFT   = 2'd0;
  localparam label_t LBL_RIGHT  = 2'd1;
  localparam label_t LBL_CENTER = 2'd2;
  localparam label_t LBL_NONE   = 2'd3;

  localparam cfg_idx_t REG_CONF_THR = 1'b0;
  localparam cfg_idx_t REG_VOTE_PCT = 1'b1;

  localparam conf_t CONF_THR_RST = 8'd0;
  localparam pct_t  VOTE_PCT_RST = 7'd60;

  typedef struct packed {
    conf_t thr;
    pct_t  pct;
  } cfg_t;

  typedef struct packed {
    logic   push;
    label_t label;
  } qwr_t;

  typedef struct packed {
    logic   valid;
    label_t label;
  } qrd_t;

  typedef struct packed {
    label_t direction;
    vote_t  vote_count;
  } result_t;

endpackage

// ----- src/wmdv_front.sv -----
// front end: configuration registers and confidence filter
module wmdv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  wmdv_pkg::cfg_idx_t  cfg_index,
  input  wmdv_pkg::cfg_data_t cfg_data,
  input  logic                in_push,
  input  wmdv_pkg::label_t    in_label,
  input  wmdv_pkg::conf_t     in_confidence,
  input  logic                q_full,
  output wmdv_pkg::qwr_t      q_wr,
  output wmdv_pkg::cfg_t      cfg
);
  import wmdv_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_CONF_THR: cfg_nxt.thr = cfg_data;
        REG_VOTE_PCT: cfg_nxt.pct = cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr <= CONF_THR_RST;
      cfg_r.pct <= VOTE_PCT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // low-confidence labels are dropped here
  assign q_wr.push  = in_push && !q_full && (in_confidence >= cfg_r.thr);
  assign q_wr.label = in_label;
  assign cfg        = cfg_r;

endmodule

// ----- src/wmdv_queue.sv -----
// two-entry label queue between front and back
module wmdv_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  wmdv_pkg::qwr_t q_wr,
  input  logic           q_pop,
  output logic           q_full,
  output wmdv_pkg::qrd_t q_rd
);
  import wmdv_pkg::*;

  label_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_pop;

  assign do_pop = q_pop && (cnt_r != 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_wr.push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!q_wr.push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_wr.push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.label;
    end
  end

  assign q_full     = (cnt_r == 2'd2);
  assign q_rd.valid = (cnt_r != 2'd0);
  assign q_rd.label = mem_r[rd_ptr_r];

endmodule

// ----- src/wmdv_back.sv -----
// back end: label ring, direction counts, vote and result queue
module wmdv_back (
  input  logic              clk,
  input  logic              rst_n,
  input  wmdv_pkg::pct_t    vote_pct,
  input  wmdv_pkg::qrd_t    q_rd,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output wmdv_pkg::result_t res
);
  import wmdv_pkg::*;

  label_t     ring_r [WINDOW_DEPTH];
  ptr_t       oldest_r;
  ptr_t       oldest_nxt;
  cnt_t       fill_r;
  cnt_t       fill_nxt;
  cnt_t       cnt_r [NUM_DIR];
  cnt_t       cnt_nxt [NUM_DIR];
  cnt_t       upd [NUM_DIR];
  label_t     evict;
  logic       ring_full;
  label_t     best_dir;
  cnt_t       best_cnt;
  logic       pass;
  logic       take;
  logic       res_push;
  logic       res_pop;
  result_t    res_mem_r [2];
  logic       res_wr_r;
  logic       res_rd_r;
  logic [1:0] res_cnt_r;
  logic [1:0] res_cnt_nxt;

  assign res_pop   = out_pop && (res_cnt_r != 2'd0);
  assign take      = q_rd.valid && ((res_cnt_r != 2'd2) || res_pop);
  assign q_pop     = take;
  assign evict     = ring_r[oldest_r];
  assign ring_full = (fill_r == CNT_W'(WINDOW_DEPTH));

  always_comb begin
    for (int d = 0; d < NUM_DIR; d++) begin
      upd[d] = cnt_r[d];
      if (ring_full && (evict == label_t'(d)) && (cnt_r[d] != '0)) begin
        upd[d] = cnt_r[d] - 1'b1;
      end
      if (q_rd.label == label_t'(d)) begin
        upd[d] = upd[d] + 1'b1;
      end
    end
  end

  // ties go to left, then right, then center
  always_comb begin
    best_dir = LBL_LEFT;
    best_cnt = upd[0];
    if (upd[1] > best_cnt) begin
      best_dir = LBL_RIGHT;
      best_cnt = upd[1];
    end
    if (upd[2] > best_cnt) begin
      best_dir = LBL_CENTER;
      best_cnt = upd[2];
    end
  end

  assign pass = (CMP_W'(best_cnt) * CMP_W'(PCT_SCALE)) >=
                (CMP_W'(vote_pct) * CMP_W'(WINDOW_DEPTH));
  assign res_push = take && ring_full && pass;

  always_comb begin
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    cnt_nxt    = cnt_r;
    if (take) begin
      if (!ring_full) begin
        fill_nxt = fill_r + 1'b1;
        cnt_nxt  = upd;
      end else if (pass) begin
        fill_nxt   = '0;
        oldest_nxt = '0;
        for (int d = 0; d < NUM_DIR; d++) begin
          cnt_nxt[d] = '0;
        end
      end else begin
        oldest_nxt = (oldest_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
        cnt_nxt    = upd;
      end
    end
  end

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (res_push && !res_pop) begin
      res_cnt_nxt = res_cnt_r + 2'd1;
    end else if (!res_push && res_pop) begin
      res_cnt_nxt = res_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      oldest_r  <= '0;
      res_wr_r  <= 1'b0;
      res_rd_r  <= 1'b0;
      res_cnt_r <= 2'd0;
      for (int d = 0; d < NUM_DIR; d++) begin
        cnt_r[d] <= '0;
      end
    end else begin
      fill_r    <= fill_nxt;
      oldest_r  <= oldest_nxt;
      cnt_r     <= cnt_nxt;
      res_cnt_r <= res_cnt_nxt;
      if (res_push) begin
        res_wr_r <= ~res_wr_r;
      end
      if (res_pop) begin
        res_rd_r <= ~res_rd_r;
      end
    end
  end

  // while filling the oldest pointer sits at zero, so the fill level is the slot
  always_ff @(posedge clk) begin
    if (take) begin
      if (ring_full) begin
        ring_r[oldest_r] <= q_rd.label;
      end else begin
        ring_r[fill_r[PTR_W-1:0]] <= q_rd.label;
      end
    end
    if (res_push) begin
      res_mem_r[res_wr_r].direction  <= best_dir;
      res_mem_r[res_wr_r].vote_count <= vote_t'(best_cnt);
    end
  end

  assign out_empty = (res_cnt_r == 2'd0);
  assign res       = res_mem_r[res_rd_r];

endmodule

// ----- src/window_majority_direction_vote.sv -----
// top level of the sliding-window direction vote
//
// usage:
//   input channel: drive in_label and in_confidence with in_push; a transaction
//   completes on a clock edge with in_push high and in_full low. labels whose
//   confidence is below the threshold register are dropped.
//   result channel: while out_empty is low, out_direction and out_vote_count
//   show the oldest decision; it leaves on an edge with out_pop high.
//   config port: cfg_we writes cfg_data to register cfg_index (0 confidence
//   threshold, 1 vote percent); user writes only while block idle, unchecked.
// timing:
//   one label per cycle while the back end is not stalled; the ring update,
//   count update and vote for a label all happen in the same back-end cycle.
//   a deciding label passes the label queue and the result queue to the ports.
// stalls:
//   a two-entry label queue and a two-entry result queue decouple the sides;
//   when the result queue is full the back end stops and the label queue
//   fills, then in_full rises.
// reset:
//   rst_n low clears window, counts and queues; threshold 0, percent 60.
module window_majority_direction_vote (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  wmdv_pkg::label_t    in_label,
  input  wmdv_pkg::conf_t     in_confidence,
  output logic                out_empty,
  input  logic                out_pop,
  output wmdv_pkg::label_t    out_direction,
  output wmdv_pkg::vote_t     out_vote_count,
  input  logic                cfg_we,
  input  wmdv_pkg::cfg_idx_t  cfg_index,
  input  wmdv_pkg::cfg_data_t cfg_data
);
  import wmdv_pkg::*;

  qwr_t    q_wr;
  qrd_t    q_rd;
  logic    q_pop;
  cfg_t    cfg;
  result_t res;

  wmdv_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_label      (in_label),
    .in_confidence (in_confidence),
    .q_full        (in_full),
    .q_wr          (q_wr),
    .cfg           (cfg)
  );

  wmdv_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_pop  (q_pop),
    .q_full (in_full),
    .q_rd   (q_rd)
  );

  wmdv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .vote_pct  (cfg.pct),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res       (res)
  );

  assign out_direction  = res.direction;
  assign out_vote_count = res.vote_count;

endmodule

// ----- src/wmdv_checker.sv -----
// port-level assertions for the direction vote block, with bind
`include "window_majority_direction_vote_defines.svh"

module wmdv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [1:0] out_direction,
  input logic [4:0] out_vote_count
);
  import wmdv_pkg::*;

  `WMDV_ASSERT_IMPL(a_dir_valid, !out_empty, out_direction != LBL_NONE, "direction none shown")
  `WMDV_ASSERT_IMPL(a_cnt_bound, !out_empty, out_vote_count <= vote_t'(WINDOW_DEPTH), "count too big")
  `WMDV_ASSERT_IMPL(a_zero_left, !out_empty && (out_vote_count == '0), out_direction == LBL_LEFT, "zero count not left")
  `WMDV_ASSERT_NEXT(a_stall_hold, !out_empty && !out_pop, !out_empty && $stable(out_direction) && $stable(out_vote_count), "stalled result changed")

endmodule

bind window_majority_direction_vote wmdv_checker u_wmdv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_direction  (out_direction),
  .out_vote_count (out_vote_count)
);
